### src/drum_pattern_event_sequencer_defines.svh
// ----------------------------------------------------------------------------
// drum pattern event sequencer assertion macros
// shared concurrent assertion forms for the sequencer rtl
// ----------------------------------------------------------------------------
`ifndef DRUM_PATTERN_EVENT_SEQUENCER_DEFINES_SVH
`define DRUM_PATTERN_EVENT_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define DPES_ASSERT_IMPL(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("sequencer assertion failed");

// next-cycle implication
`define DPES_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");

`endif

### src/dpes_pkg.sv
// ----------------------------------------------------------------------------
// dpes_pkg
// shared types and constants of the drum pattern event sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package dpes_pkg;

    localparam int MTIME_W    = 32;
    localparam int INDEX_W    = 5;
    localparam int TIME_W     = 11;
    localparam int POS_FULL_W = 16;
    localparam int LEN_W      = 6;

    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = 6;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_RESYNC = 2'd2;

    localparam logic [7:0] TYPE_MASK  = 8'hF0;
    localparam logic [7:0] CHAN_MASK  = 8'h0F;
    localparam logic [7:0] STATUS_ON  = 8'h90;
    localparam logic [7:0] STATUS_OFF = 8'h80;

    typedef struct packed {
        logic [1:0]            kind;
        logic [POS_FULL_W-1:0] pos;
        logic [INDEX_W-1:0]    index;
        logic [TIME_W-1:0]     etime;
        logic [7:0]            status;
        logic [6:0]            note;
        logic [6:0]            velocity;
    } cmd_t;

    typedef struct packed {
        logic       note_on;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [3:0] channel;
        logic       knock;
        logic       last;
    } res_t;

endpackage

`default_nettype wire

### src/dpes_fifo.sv
// ----------------------------------------------------------------------------
// dpes_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
`default_nettype none

module dpes_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_W-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

### src/dpes_front.sv
// ----------------------------------------------------------------------------
// dpes_front
// accepts items, reduces music time to a bar position, queues commands
// ----------------------------------------------------------------------------
`default_nettype none

module dpes_front #(
    parameter int BAR_TICKS = 1920
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    kind,
    input  logic [31:0]   music_time,
    input  logic [4:0]    entry_index,
    input  logic [10:0]   entry_time,
    input  logic [7:0]    entry_status,
    input  logic [6:0]    entry_note,
    input  logic [6:0]    entry_velocity,
    output logic          cmd_push,
    output dpes_pkg::cmd_t cmd_data,
    input  logic          cmd_full
);

    import dpes_pkg::*;

    // floor(n / BAR_TICKS) = (n * RECIP) >> RSHIFT for every 32-bit n
    localparam int RSHIFT = MTIME_W + $clog2(BAR_TICKS);
    localparam int PROD_W = 2 * MTIME_W + 1;
    localparam logic [MTIME_W:0] RECIP =
        (MTIME_W + 1)'(((64'd1 << RSHIFT) / 64'(BAR_TICKS)) + 64'd1);
    localparam logic [MTIME_W-1:0] BAR_MUL = MTIME_W'(BAR_TICKS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_QMUL = 3'd2;
    localparam logic [2:0] ST_SUB  = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    cmd_t                 item_reg;
    cmd_t                 item_next;
    logic [MTIME_W-1:0]   dividend_reg;
    logic [MTIME_W-1:0]   dividend_next;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;
    logic [MTIME_W-1:0]   qd_reg;
    logic [MTIME_W-1:0]   qd_next;
    logic [MTIME_W-1:0]   quot;
    logic                 accept;

    assign full     = (state_reg != ST_IDLE);
    assign accept   = push && !full;
    assign cmd_push = (state_reg == ST_PUSH) && !cmd_full;
    assign cmd_data = item_reg;

    assign quot     = MTIME_W'(prod_reg >> RSHIFT);

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        dividend_next = dividend_reg;
        prod_next     = prod_reg;
        qd_next       = qd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next.kind     = kind;
                    item_next.pos      = '0;
                    item_next.index    = entry_index;
                    item_next.etime    = entry_time;
                    item_next.status   = entry_status;
                    item_next.note     = entry_note;
                    item_next.velocity = entry_velocity;
                    dividend_next      = music_time;
                    case (kind)
                        KIND_TICK, KIND_RESYNC: state_next = ST_MUL;
                        KIND_WRITE:             state_next = ST_PUSH;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL:
            begin
                // 32 x 33 bit reciprocal product
                prod_next  = PROD_W'(dividend_reg) * PROD_W'(RECIP);
                state_next = ST_QMUL;
            end
            ST_QMUL:
            begin
                qd_next    = quot * BAR_MUL;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                item_next.pos = POS_FULL_W'(dividend_reg - qd_reg);
                state_next    = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!cmd_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        dividend_reg <= dividend_next;
        prod_reg     <= prod_next;
        qd_reg       <= qd_next;
    end

endmodule

`default_nettype wire

### src/dpes_back.sv
// ----------------------------------------------------------------------------
// dpes_back
// executes commands: pattern table writes, resync and tick window scans
// ----------------------------------------------------------------------------
`default_nettype none

`include "drum_pattern_event_sequencer_defines.svh"

module dpes_back #(
    parameter int TABLE_DEPTH = 32,
    parameter int BAR_TICKS   = 1920
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_empty,
    input  dpes_pkg::cmd_t cmd_data,
    output logic           cmd_pop,
    input  logic [5:0]     pattern_length,
    output logic           res_push,
    output dpes_pkg::res_t res_data,
    input  logic           res_full
);

    import dpes_pkg::*;

    localparam int POS_W  = (BAR_TICKS > 1) ? $clog2(BAR_TICKS) : 1;
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LW     = (LEN_W > CNT_W) ? LEN_W : CNT_W;
    localparam int BAR_W  = $clog2(BAR_TICKS + 1);
    localparam int WIN_W  = (TIME_W > BAR_W) ? TIME_W : BAR_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] etime;
        logic [7:0]        status;
        logic [6:0]        note;
        logic [6:0]        velocity;
    } entry_t;

    entry_t             mem [TABLE_DEPTH];
    entry_t             rd_data_reg;
    entry_t             wr_entry;
    logic               mem_we;
    logic [IDX_W-1:0]   wr_addr;
    logic               rd_en;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [POS_W-1:0]   prev_reg;
    logic [POS_W-1:0]   prev_next;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    logic               eval_vld_reg;
    logic               eval_vld_next;
    logic [WIN_W-1:0]   after_reg;
    logic [WIN_W-1:0]   after_next;
    logic [WIN_W-1:0]   upto_reg;
    logic [WIN_W-1:0]   upto_next;
    logic               all_low_reg;
    logic               all_low_next;
    logic               zero_pend_reg;
    logic               zero_pend_next;
    logic [RES_CNT_W-1:0] cnt_reg;
    logic [RES_CNT_W-1:0] cnt_next;
    logic               any_on_reg;
    logic               any_on_next;
    logic               pend_vld_reg;
    logic               pend_vld_next;
    res_t               pend_reg;
    res_t               pend_next;

    logic [LW-1:0]      len_ext;
    logic [CNT_W-1:0]   n_eff;
    logic [POS_W-1:0]   cmd_pos;
    logic [WIN_W-1:0]   t_ext;
    logic               is_on;
    logic               is_off;
    logic               in_win;
    logic               brk;
    logic               found;
    logic               keep;
    logic               stall;
    logic               issue;
    logic               phase_done;
    res_t               new_res;

    assign len_ext = LW'(pattern_length);
    assign n_eff   = (len_ext > LW'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(len_ext);
    assign cmd_pos = cmd_data.pos[POS_W-1:0];
    assign cmd_pop = (state_reg == ST_IDLE) && !cmd_empty;

    assign wr_addr  = IDX_W'(cmd_data.index);
    assign mem_we   = cmd_pop && (cmd_data.kind == KIND_WRITE)
                      && (32'(cmd_data.index) < 32'(TABLE_DEPTH));
    assign wr_entry = '{etime: cmd_data.etime, status: cmd_data.status,
                        note: cmd_data.note, velocity: cmd_data.velocity};

    // entry under evaluation
    assign t_ext  = WIN_W'(rd_data_reg.etime);
    assign is_on  = ((rd_data_reg.status & TYPE_MASK) == STATUS_ON);
    assign is_off = ((rd_data_reg.status & TYPE_MASK) == STATUS_OFF);
    assign in_win = eval_vld_reg && (all_low_reg || (after_reg < t_ext)) && (t_ext <= upto_reg);
    assign brk    = eval_vld_reg && (t_ext > upto_reg);
    assign found  = in_win && (is_on || is_off);
    assign keep   = found && (cnt_reg < RES_CNT_W'(MAX_RESULTS));
    assign stall  = keep && pend_vld_reg && res_full;
    assign issue  = (state_reg == ST_SCAN) && !stall && !brk && (idx_reg < n_eff);
    assign rd_en  = issue;
    assign phase_done = brk || (!eval_vld_reg && (idx_reg >= n_eff));

    always_comb
    begin
        new_res.note_on  = is_on;
        new_res.note     = rd_data_reg.note;
        new_res.velocity = rd_data_reg.velocity;
        new_res.channel  = 4'(rd_data_reg.status & CHAN_MASK);
        new_res.knock    = 1'b0;
        new_res.last     = 1'b0;
    end

    always_comb
    begin
        res_data = pend_reg;
        res_push = 1'b0;
        if (state_reg == ST_FINISH)
        begin
            res_data.last  = 1'b1;
            res_data.knock = any_on_reg;
            res_push       = pend_vld_reg && !res_full;
        end
        else if (state_reg == ST_SCAN)
        begin
            res_push = !stall && keep && pend_vld_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        idx_next       = idx_reg;
        eval_vld_next  = eval_vld_reg;
        after_next     = after_reg;
        upto_next      = upto_reg;
        all_low_next   = all_low_reg;
        zero_pend_next = zero_pend_reg;
        cnt_next       = cnt_reg;
        any_on_next    = any_on_reg;
        pend_vld_next  = pend_vld_reg;
        pend_next      = pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_pop)
                begin
                    case (cmd_data.kind)
                        KIND_RESYNC:
                        begin
                            prev_next = cmd_pos;
                        end
                        KIND_TICK:
                        begin
                            prev_next      = cmd_pos;
                            idx_next       = '0;
                            eval_vld_next  = 1'b0;
                            cnt_next       = '0;
                            any_on_next    = 1'b0;
                            pend_vld_next  = 1'b0;
                            after_next     = WIN_W'(prev_reg);
                            upto_next      = WIN_W'(cmd_pos);
                            all_low_next   = 1'b0;
                            zero_pend_next = 1'b0;
                            if (cmd_pos == '0)
                            begin
                                if (prev_reg != '0)
                                begin
                                    upto_next      = WIN_W'(BAR_TICKS);
                                    zero_pend_next = 1'b1;
                                end
                                else
                                begin
                                    after_next   = '0;
                                    all_low_next = 1'b1;
                                end
                            end
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    if (found && is_on)
                    begin
                        any_on_next = 1'b1;
                    end
                    if (keep)
                    begin
                        pend_next     = new_res;
                        pend_vld_next = 1'b1;
                        cnt_next      = cnt_reg + 1'b1;
                    end
                    if (issue)
                    begin
                        idx_next      = idx_reg + 1'b1;
                        eval_vld_next = 1'b1;
                    end
                    else
                    begin
                        eval_vld_next = 1'b0;
                    end
                    if (phase_done)
                    begin
                        if (zero_pend_reg)
                        begin
                            after_next     = '0;
                            upto_next      = '0;
                            all_low_next   = 1'b1;
                            zero_pend_next = 1'b0;
                            idx_next       = '0;
                            eval_vld_next  = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!res_full)
                begin
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            prev_reg     <= '0;
            eval_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            prev_reg     <= prev_next;
            eval_vld_reg <= eval_vld_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        after_reg     <= after_next;
        upto_reg      <= upto_next;
        all_low_reg   <= all_low_next;
        zero_pend_reg <= zero_pend_next;
        cnt_reg       <= cnt_next;
        any_on_reg    <= any_on_next;
        pend_reg      <= pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    `DPES_ASSERT_IMPL(a_push_not_full, clk, rst_n, res_push, !res_full)
    `DPES_ASSERT_IMPL(a_cnt_bound, clk, rst_n, state_reg == ST_SCAN, cnt_reg <= RES_CNT_W'(MAX_RESULTS))
    `DPES_ASSERT_IMPL(a_read_in_range, clk, rst_n, rd_en, idx_reg < n_eff)
    `DPES_ASSERT_NEXT(a_last_drains, clk, rst_n, res_push && res_data.last, !pend_vld_reg && state_reg == ST_IDLE)

endmodule

`default_nettype wire

### src/drum_pattern_event_sequencer.sv
// a tick or resync runs ST_MUL, ST_QMUL (reciprocal multiply), ST_SUB, ST_PUSH, a write ST_PUSH
// a tick scan in the back reads up to pattern_length table entries, one table read a cycle unless stalled,
// and scans the table twice when a bar wrap flushes the bar end before time zero
// sustained rate is set by the back, which takes a new command only once idle, plus stalls
// reset clears the queues, the previous bar position and pattern_length; the table is not cleared
// ----------------------------------------------------------------------------
// drum_pattern_event_sequencer
// plays a time-sorted table of midi drum events against musical-time ticks
// ----------------------------------------------------------------------------
`default_nettype none

module drum_pattern_event_sequencer #(
    parameter int TABLE_DEPTH = 32,
    parameter int BAR_TICKS   = 1920
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [31:0] music_time,
    input  logic [4:0]  entry_index,
    input  logic [10:0] entry_time,
    input  logic [7:0]  entry_status,
    input  logic [6:0]  entry_note,
    input  logic [6:0]  entry_velocity,
    input  logic        pop,
    output logic        empty,
    output logic        note_on,
    output logic [6:0]  note,
    output logic [6:0]  velocity,
    output logic [3:0]  channel,
    output logic        knock,
    output logic        last
);

    import dpes_pkg::*;

    localparam logic REG_PATTERN_LENGTH = 1'b0;
    localparam int   QUEUE_DEPTH        = 2;

    logic [LEN_W-1:0] len_reg;
    logic             cfg_wr;

    cmd_t cmd_wdata;
    cmd_t cmd_rdata;
    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;

    res_t res_wdata;
    res_t res_rdata;
    logic res_push;
    logic res_full;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PATTERN_LENGTH);
    assign prdata = (paddr[2] == REG_PATTERN_LENGTH) ? 32'(len_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_wr)
        begin
            len_reg <= pwdata[LEN_W-1:0];
        end
    end

    dpes_front #(
        .BAR_TICKS (BAR_TICKS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .kind           (kind),
        .music_time     (music_time),
        .entry_index    (entry_index),
        .entry_time     (entry_time),
        .entry_status   (entry_status),
        .entry_note     (entry_note),
        .entry_velocity (entry_velocity),
        .cmd_push       (cmd_push),
        .cmd_data       (cmd_wdata),
        .cmd_full       (cmd_full)
    );

    dpes_fifo #(
        .DATA_W ($bits(cmd_t)),
        .DEPTH  (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    dpes_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .BAR_TICKS   (BAR_TICKS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_empty      (cmd_empty),
        .cmd_data       (cmd_rdata),
        .cmd_pop        (cmd_pop),
        .pattern_length (len_reg),
        .res_push       (res_push),
        .res_data       (res_wdata),
        .res_full       (res_full)
    );

    dpes_fifo #(
        .DATA_W ($bits(res_t)),
        .DEPTH  (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign note_on  = res_rdata.note_on;
    assign note     = res_rdata.note;
    assign velocity = res_rdata.velocity;
    assign channel  = res_rdata.channel;
    assign knock    = res_rdata.knock;
    assign last     = res_rdata.last;

endmodule

`default_nettype wire
